### rtl/hsxa_pkg.sv
package hsxa_pkg;

    localparam int FieldW = 12;
    localparam int AngleW = 16;
    localparam int CordicStages = 16;
    localparam int AngleFracBits = 7;
    localparam int AccFrac = 20;
    localparam int TableLen = 24;
    localparam int PreShift = 24;
    localparam int DataW = FieldW + PreShift + 4;
    localparam int AccW = 30;
    localparam int QueueDepth = 4;
    localparam int QueueAw = $clog2(QueueDepth);
    localparam int RoundShift = AccFrac - AngleFracBits;
    localparam int UsedStages = (CordicStages < TableLen) ? CordicStages : TableLen;

    typedef struct packed {
        logic [31:0] reg28_word;
        logic [31:0] reg29_word;
    } t_in_req;

    typedef struct packed {
        logic signed [FieldW-1:0] field_x;
        logic signed [FieldW-1:0] field_y;
        logic signed [FieldW-1:0] field_z;
        logic signed [AngleW-1:0] angle_xy;
        logic signed [AngleW-1:0] angle_xz;
        logic signed [AngleW-1:0] angle_yz;
    } t_out_req;

    typedef struct packed {
        logic signed [FieldW-1:0] fx;
        logic signed [FieldW-1:0] fy;
        logic signed [FieldW-1:0] fz;
    } t_fields;

    typedef struct packed {
        logic signed [DataW-1:0] x;
        logic signed [DataW-1:0] y;
        logic signed [AccW-1:0] z;
        logic                   bypass;
        logic signed [AngleW-1:0] fixed;
    } t_cordic;

    function automatic logic signed [AccW-1:0] atan_q20(input int idx);
        logic signed [AccW-1:0] t [TableLen];
        t = '{30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121, 30'sd3750058,
              30'sd1876857, 30'sd938658, 30'sd469357, 30'sd234682, 30'sd117342,
              30'sd58671, 30'sd29335, 30'sd14668, 30'sd7334, 30'sd3667, 30'sd1833,
              30'sd917, 30'sd458, 30'sd229, 30'sd115, 30'sd57, 30'sd29, 30'sd14, 30'sd7};
        return t[idx];
    endfunction

endpackage

### rtl/hsxa_cordic.sv
module hsxa_cordic (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [hsxa_pkg::FieldW-1:0]  i_a,
    input  logic signed [hsxa_pkg::FieldW-1:0]  i_b,
    output logic signed [hsxa_pkg::AngleW-1:0]  o_angle
);
    localparam int N = hsxa_pkg::UsedStages;
    localparam int DW = hsxa_pkg::DataW;
    localparam int AW = hsxa_pkg::AccW;
    localparam logic signed [hsxa_pkg::AngleW-1:0] Lim =
        hsxa_pkg::AngleW'(180 << hsxa_pkg::AngleFracBits);
    localparam logic signed [hsxa_pkg::AngleW-1:0] Right =
        hsxa_pkg::AngleW'(90 << hsxa_pkg::AngleFracBits);
    localparam logic signed [AW-1:0] Z90 = AW'(90 << hsxa_pkg::AccFrac);

    hsxa_pkg::t_cordic r_st [N+1];
    hsxa_pkg::t_cordic n_st0;
    logic signed [DW-1:0] x0;
    logic signed [DW-1:0] y0;
    logic signed [AW-1:0] zr;
    logic signed [AW-1:0] zq;
    logic signed [hsxa_pkg::AngleW-1:0] n_angle;

    always_comb begin
        x0 = DW'(i_a) <<< hsxa_pkg::PreShift;
        y0 = DW'(i_b) <<< hsxa_pkg::PreShift;
        n_st0 = '0;
        n_st0.bypass = (i_a == 0) || (i_b == 0);
        if (i_b == 0) begin
            n_st0.fixed = (i_a > 0 || i_a == 0) ? '0 : Lim;
            if (i_a == 0) n_st0.fixed = '0;
        end else begin
            n_st0.fixed = (i_b > 0) ? Right : -Right;
        end
        n_st0.x = x0;
        n_st0.y = y0;
        if (i_a < 0) begin
            if (i_b >= 0) begin
                n_st0.x = y0;
                n_st0.y = -x0;
                n_st0.z = Z90;
            end else begin
                n_st0.x = -y0;
                n_st0.y = x0;
                n_st0.z = -Z90;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_st[0] <= n_st0;
    end

    for (genvar g = 0; g < N; g++) begin : g_stage
        hsxa_pkg::t_cordic n_s;
        always_comb begin
            n_s = r_st[g];
            if (r_st[g].y >= 0) begin
                n_s.x = r_st[g].x + (r_st[g].y >>> g);
                n_s.y = r_st[g].y - (r_st[g].x >>> g);
                n_s.z = r_st[g].z + hsxa_pkg::atan_q20(g);
            end else begin
                n_s.x = r_st[g].x - (r_st[g].y >>> g);
                n_s.y = r_st[g].y + (r_st[g].x >>> g);
                n_s.z = r_st[g].z - hsxa_pkg::atan_q20(g);
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) r_st[g+1] <= n_s;
        end
    end

    always_comb begin
        zr = r_st[N].z + (AW'(1) <<< (hsxa_pkg::RoundShift - 1));
        zq = zr >>> hsxa_pkg::RoundShift;
        if (r_st[N].bypass) begin
            n_angle = r_st[N].fixed;
        end else if (zq > AW'(Lim)) begin
            n_angle = Lim;
        end else if (zq < -AW'(Lim)) begin
            n_angle = -Lim;
        end else begin
            n_angle = zq[hsxa_pkg::AngleW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) o_angle <= n_angle;
    end
endmodule

### rtl/hsxa_front.sv
module hsxa_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  hsxa_pkg::t_in_req     i_req,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_empty,
    output hsxa_pkg::t_fields     o_fields
);
    localparam int D = hsxa_pkg::QueueDepth;
    localparam int AW = hsxa_pkg::QueueAw;

    hsxa_pkg::t_fields r_mem [D];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;
    hsxa_pkg::t_fields n_f;
    logic do_push;
    logic do_pop;

    assign o_full = (r_cnt == (AW+1)'(D));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && !o_empty;
    assign o_fields = r_mem[r_rp];

    always_comb begin
        n_f.fx = {i_req.reg28_word[31:24], i_req.reg29_word[19:16]};
        n_f.fy = {i_req.reg28_word[23:16], i_req.reg29_word[15:12]};
        n_f.fz = {i_req.reg28_word[15:8], i_req.reg29_word[11:8]};
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= n_f;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end
endmodule

### rtl/hsxa_back.sv
module hsxa_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  hsxa_pkg::t_fields     i_fields,
    output logic                  o_take,
    input  logic                  i_pop,
    output logic                  o_empty,
    output hsxa_pkg::t_out_req    o_res
);
    localparam int L = hsxa_pkg::UsedStages + 2;

    logic [L-1:0] r_v;
    hsxa_pkg::t_fields r_f [L];
    logic en;
    logic signed [hsxa_pkg::AngleW-1:0] a_xy;
    logic signed [hsxa_pkg::AngleW-1:0] a_xz;
    logic signed [hsxa_pkg::AngleW-1:0] a_yz;

    // pipeline advances unless the result at its end is held
    assign en = !(r_v[L-1] && !i_pop);
    assign o_take = en && i_valid;
    assign o_empty = !r_v[L-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[L-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f[0] <= i_fields;
            for (int k = 1; k < L; k++) r_f[k] <= r_f[k-1];
        end
    end

    hsxa_cordic u_xy (.i_clk, .i_en(en), .i_a(i_fields.fx), .i_b(i_fields.fy), .o_angle(a_xy));
    hsxa_cordic u_xz (.i_clk, .i_en(en), .i_a(i_fields.fx), .i_b(i_fields.fz), .o_angle(a_xz));
    hsxa_cordic u_yz (.i_clk, .i_en(en), .i_a(i_fields.fy), .i_b(i_fields.fz), .o_angle(a_yz));

    always_comb begin
        o_res.field_x = r_f[L-1].fx;
        o_res.field_y = r_f[L-1].fy;
        o_res.field_z = r_f[L-1].fz;
        o_res.angle_xy = a_xy;
        o_res.angle_xz = a_xz;
        o_res.angle_yz = a_yz;
    end
endmodule

### rtl/hall_sensor_xyz_angle_core.sv
// a request passes from the input queue through 18 pipeline registers to the output
// one request per cycle unless stalled; three 16-stage angle pipelines run in parallel
// the result pipeline stalls as a whole while its last result is not popped
// reset: synchronous, active low; clears the input queue and all valid bits
module hall_sensor_xyz_angle_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  hsxa_pkg::t_in_req  i_req,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output hsxa_pkg::t_out_req o_res
);
    logic q_empty;
    logic take;
    hsxa_pkg::t_fields q_f;

    hsxa_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .i_req, .o_full(full),
        .i_pop(take), .o_empty(q_empty), .o_fields(q_f)
    );

    hsxa_back u_back (
        .i_clk, .i_rst_n, .i_valid(!q_empty), .i_fields(q_f), .o_take(take),
        .i_pop(pop), .o_empty(empty), .o_res
    );
endmodule
